@@ rtl/core/integer_matrix_multiply_macros.svh @@
// Assertion macros shared by the matrix multiply RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication
`define IMM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/imm_pkg.sv @@
// Shared types and constants for the integer matrix multiply block.
// No dependencies; compiled first.
package imm_pkg;

  localparam int MAX_DIM   = 32;
  localparam int VALUE_W   = 32;
  localparam int CFG_W     = 6;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ACT_W     = 2;
  localparam int REG_SEL_W = 2;
  localparam int DIM_RESET = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_WRITE_B = 2'd1,
    ACT_READ    = 2'd2
  } action_t;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic step;
    logic load_result;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic range_err;
    logic kd_zero;
    logic last_step;
    logic busy;
    logic out_full;
  } ctl_sts_t;

endpackage

@@ rtl/core/imm_item_if.sv @@
// Input item channel: valid/ready plus one operation.
// Depends on imm_pkg.
interface imm_item_if import imm_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic [IDX_W-1:0]          row_index;
  logic [IDX_W-1:0]          col_index;
  logic signed [VALUE_W-1:0] element_value;

  modport source (output valid, action, row_index, col_index, element_value,
                  input ready);
  modport sink   (input valid, action, row_index, col_index, element_value,
                  output ready);
endinterface

@@ rtl/core/imm_result_if.sv @@
// Result channel: valid/ready plus one product element.
// Depends on imm_pkg.
interface imm_result_if import imm_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] product_value;
  logic                      index_error;

  modport source (output valid, product_value, index_error, input ready);
  modport sink   (input valid, product_value, index_error, output ready);
endinterface

@@ rtl/core/imm_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and data.
// Depends on imm_pkg.
interface imm_cfg_if import imm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [REG_SEL_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/integer_matrix_multiply.sv @@
// Integer matrix multiply, one product element per read item. Write items
// store an element of A or B and give no result; a read item returns the
// wrapped 32-bit dot product of one A row and one B column. A read walks
// inner_dim element pairs through a single multiply-accumulate unit fed by
// two registered-read RAMs; an out-of-range read skips the walk. One item is
// in work at a time; a finished result waits in an output register while the
// next item is taken. Size registers must be written only while idle; the
// block itself does not enforce this.
module integer_matrix_multiply import imm_pkg::*; (
  input logic           clk,
  input logic           rst,
  imm_item_if.sink      item,
  imm_result_if.source  result,
  imm_cfg_if.sink       cfg
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  imm_controller u_ctl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  imm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .action        (item.action),
    .row_index     (item.row_index),
    .col_index     (item.col_index),
    .element_value (item.element_value),
    .cmd           (cmd),
    .sts           (sts),
    .result        (result),
    .cfg           (cfg)
  );

endmodule

@@ rtl/core/imm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/imm_datapath.sv @@
// Datapath: size registers, A/B element stores, multiply-accumulate pipe
// and result register. Depends on imm_pkg, imm_ram, imm_result_if, imm_cfg_if.
`include "integer_matrix_multiply_macros.svh"

module imm_datapath import imm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ACT_W-1:0]          action,
  input  logic [IDX_W-1:0]          row_index,
  input  logic [IDX_W-1:0]          col_index,
  input  logic signed [VALUE_W-1:0] element_value,
  input  ctl_cmd_t                  cmd,
  output ctl_sts_t                  sts,
  imm_result_if.source              result,
  imm_cfg_if.sink                   cfg
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int CMP_W  = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int MUL_W  = ADDR_W + CMP_W;
  localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

  function automatic logic [CMP_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    return (ve > MAX_DIM_C) ? MAX_DIM_C : ve;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CMP_W-1:0] r,
                                                input logic [CMP_W-1:0] c);
    logic [MUL_W-1:0] full;
    full = MUL_W'(r) * MUL_W'(MAX_DIM) + MUL_W'(c);
    return full[ADDR_W-1:0];
  endfunction

  // size registers
  logic [CFG_W-1:0] rows_a;
  logic [CFG_W-1:0] inner_dim;
  logic [CFG_W-1:0] cols_b;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= CFG_W'(DIM_RESET);
      inner_dim <= CFG_W'(DIM_RESET);
      cols_b    <= CFG_W'(DIM_RESET);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ROWS_A:    rows_a    <= cfg.data;
        REG_INNER_DIM: inner_dim <= cfg.data;
        REG_COLS_B:    cols_b    <= cfg.data;
        default: ;
      endcase
    end
  end

  logic [CMP_W-1:0] row_in;
  logic [CMP_W-1:0] col_in;
  logic [CNT_W-1:0] kd_eff;
  logic             in_bounds;
  logic             range_err;
  logic             we_a;
  logic             we_b;

  assign row_in    = CMP_W'(row_index);
  assign col_in    = CMP_W'(col_index);
  assign kd_eff    = CNT_W'(clamp_dim(inner_dim));
  assign in_bounds = (row_in < MAX_DIM_C) && (col_in < MAX_DIM_C);
  assign range_err = (row_in >= clamp_dim(rows_a)) || (col_in >= clamp_dim(cols_b));
  assign we_a      = cmd.accept && (action == ACT_WRITE_A) && in_bounds;
  assign we_b      = cmd.accept && (action == ACT_WRITE_B) && in_bounds;

  // read context
  logic [IDX_W-1:0] row_q;
  logic [IDX_W-1:0] col_q;
  logic             err_q;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] k_next;

  assign k_next = k + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_q <= row_index;
      col_q <= col_index;
      err_q <= range_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.start) begin
      k <= '0;
    end else if (cmd.step) begin
      k <= k_next;
    end
  end

  logic [ADDR_W-1:0]  a_raddr;
  logic [ADDR_W-1:0]  b_raddr;
  logic [ADDR_W-1:0]  waddr;
  logic [VALUE_W-1:0] a_rd;
  logic [VALUE_W-1:0] b_rd;

  assign waddr   = addr_of(row_in, col_in);
  assign a_raddr = addr_of(CMP_W'(row_q), CMP_W'(k));
  assign b_raddr = addr_of(CMP_W'(k), CMP_W'(col_q));

  imm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (element_value),
    .re    (cmd.step),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

  imm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (element_value),
    .re    (cmd.step),
    .raddr (b_raddr),
    .rdata (b_rd)
  );

  // multiply-accumulate pipe, low VALUE_W bits only
  logic               rd_vld;
  logic               prod_vld;
  logic [VALUE_W-1:0] prod;
  logic [VALUE_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= cmd.step;
      prod_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_rd * b_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + prod;
    end
  end

  // result register
  logic                      out_full;
  logic signed [VALUE_W-1:0] product_value;
  logic                      index_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.load_result) begin
      out_full <= 1'b1;
    end else if (result.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      product_value <= err_q ? '0 : acc;
      index_error   <= err_q;
    end
  end

  assign result.valid         = out_full;
  assign result.product_value = product_value;
  assign result.index_error   = index_error;

  assign sts.is_read   = (action == ACT_READ);
  assign sts.range_err = range_err;
  assign sts.kd_zero   = (kd_eff == '0);
  assign sts.last_step = (k_next == kd_eff);
  assign sts.busy      = rd_vld || prod_vld;
  assign sts.out_full  = out_full;

  `IMM_ASSERT_NOW(a_err_zero, clk, rst, out_full && index_error, product_value == '0, "index error with nonzero value")
  `IMM_ASSERT_NEXT(a_start_clear, clk, rst, cmd.start, acc == '0 && k == '0, "read start did not clear accumulator")
  `IMM_ASSERT_NOW(a_write_quiet, clk, rst, we_a || we_b, !rd_vld && !prod_vld && !cmd.step, "store write during a dot product")

endmodule

@@ rtl/core/imm_controller.sv @@
// Controller FSM: accepts items, sequences the dot-product walk, loads result.
// Depends on imm_pkg.
`include "integer_matrix_multiply_macros.svh"

module imm_controller import imm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    item_ready      = 1'b0;
    cmd.accept      = 1'b0;
    cmd.start       = 1'b0;
    cmd.step        = 1'b0;
    cmd.load_result = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          if (sts.is_read) begin
            cmd.start = 1'b1;
            if (sts.range_err) begin
              state_next = ST_DONE;
            end else if (sts.kd_zero) begin
              state_next = ST_DRAIN;
            end else begin
              state_next = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (sts.last_step) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_full) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `IMM_ASSERT_NOW(a_ready_quiet, clk, rst, item_ready, !sts.busy, "item taken while pipe busy")
  `IMM_ASSERT_NOW(a_load_free, clk, rst, cmd.load_result, !sts.out_full, "result overwritten")
  `IMM_ASSERT_NOW(a_load_drained, clk, rst, cmd.load_result, !sts.busy, "result loaded before pipe drained")

endmodule
